// ----- sv/catmull_rom_point_eval_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Catmull-Rom point evaluator assertion macros
// Shared property wrappers for the concurrent checks of the evaluator.
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_POINT_EVAL_UNIT_DEFINES_SVH
`define CATMULL_ROM_POINT_EVAL_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define CR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define CR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/cr_pkg.sv -----
// ----------------------------------------------------------------------------
// Catmull-Rom evaluator package
// Widths, codes and control types shared by the evaluator modules.
// ----------------------------------------------------------------------------
package cr_pkg;

  localparam int CoordW    = 32;             // Q16.16 coordinate
  localparam int AddrW     = 8;              // waypoint index
  localparam int Depth     = 256;            // waypoint store depth
  localparam int CntW      = 9;              // point_count register
  localparam int TFracBits = 16;             // fraction bits of t
  localparam int TW        = TFracBits + 1;  // t field, 1.0 included
  localparam int CoefW     = CoordW + 6;     // cubic coefficients and Horner sum
  localparam int ProdW     = CoefW + TW + 1; // Horner product

  localparam logic [TW-1:0]   TOne     = TW'(1) << TFracBits;
  localparam logic [CntW-1:0] MaxCount = CntW'(Depth);

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic [1:0] STAT_STORE = 2'd0;
  localparam logic [1:0] STAT_EVAL  = 2'd1;
  localparam logic [1:0] STAT_ERR   = 2'd2;

  localparam logic [2:0] REG_POINT_COUNT = 3'd0;

  typedef enum logic [1:0] {
    TAP_P0,
    TAP_P1,
    TAP_P2,
    TAP_P3
  } tap_e;

  typedef enum logic [1:0] {
    COEF_C,
    COEF_B,
    COEF_A
  } coef_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_e;

  // Control shared by both coordinate lanes.
  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [AddrW-1:0] addr;
    tap_e             tap;
    logic             mul_en;
    logic             add_en;
    coef_e            coef;
    logic [TW-1:0]    t;
  } cr_lane_ctrl_t;

endpackage

// ----- sv/cr_in_if.sv -----
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one store or evaluate command.
// ----------------------------------------------------------------------------
interface cr_in_if
  import cr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [AddrW-1:0]         point_index;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic [TW-1:0]            t_frac;

  modport source (output valid, cmd, point_index, point_x, point_y, t_frac,
                  input ready);
  modport sink   (input valid, cmd, point_index, point_x, point_y, t_frac,
                  output ready);
endinterface

// ----- sv/cr_out_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one evaluated point and its status.
// ----------------------------------------------------------------------------
interface cr_out_if
  import cr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] out_x;
  logic signed [CoordW-1:0] out_y;
  logic [1:0]               status;

  modport source (output valid, out_x, out_y, status, input ready);
  modport sink   (input valid, out_x, out_y, status, output ready);
endinterface

// ----- sv/cr_lane.sv -----
// ----------------------------------------------------------------------------
// Catmull-Rom coordinate lane
// Waypoint store for one axis, coefficient accumulation and Horner unit.
// ----------------------------------------------------------------------------
module cr_lane
  import cr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cr_lane_ctrl_t            ctrl_i,
  input  logic signed [CoordW-1:0] wdata_i,
  output logic signed [CoordW-1:0] res_o
);

  logic [CoordW-1:0]        mem_q [Depth];
  logic [CoordW-1:0]        rdata_q;
  logic                     acc_q;
  tap_e                     tap_q;
  logic signed [CoefW-1:0]  a_q, a_d, b_q, b_d, c_q, c_d, h_q, h_d;
  logic signed [ProdW-1:0]  prod_q, prod_d;
  logic signed [CoefW-1:0]  pe, p3, p5, rnd;
  logic signed [ProdW-1:0]  rnd_sum;
  logic signed [TW:0]       t_s;
  logic signed [CoefW:0]    fin_sum;
  logic signed [CoefW-1:0]  half;
  logic                     fits;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.addr] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[ctrl_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 1'b0;
      tap_q <= TAP_P0;
    end else begin
      acc_q <= ctrl_i.rd_en;
      tap_q <= ctrl_i.tap;
    end
  end

  assign pe  = {{(CoefW-CoordW){rdata_q[CoordW-1]}}, rdata_q};
  assign p3  = (pe <<< 1) + pe;
  assign p5  = (pe <<< 2) + pe;
  assign t_s = {1'b0, ctrl_i.t};

  // Round half up: add half an ulp, keep the arithmetic-shifted bits.
  assign rnd_sum = prod_q + (ProdW'(1) <<< (TFracBits - 1));
  assign rnd     = signed'(rnd_sum[TFracBits +: CoefW]);

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    c_d    = c_q;
    h_d    = h_q;
    prod_d = prod_q;
    // Fold each neighbor into the coefficients as it arrives; h starts as d.
    if (acc_q) begin
      case (tap_q)
        TAP_P0: begin
          b_d = -pe;
          c_d = pe <<< 1;
          h_d = -pe;
        end
        TAP_P1: begin
          a_d = pe <<< 1;
          c_d = c_q - p5;
          h_d = h_q + p3;
        end
        TAP_P2: begin
          b_d = b_q + pe;
          c_d = c_q + (pe <<< 2);
          h_d = h_q - p3;
        end
        default: begin
          c_d = c_q - pe;
          h_d = h_q + pe;
        end
      endcase
    end
    if (ctrl_i.mul_en) begin
      prod_d = h_q * t_s;
    end
    if (ctrl_i.add_en) begin
      case (ctrl_i.coef)
        COEF_C:  h_d = c_q + rnd;
        COEF_B:  h_d = b_q + rnd;
        COEF_A:  h_d = a_q + rnd;
        default: h_d = h_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    h_q    <= h_d;
    prod_q <= prod_d;
  end

  // Halve with round half up, then saturate to the coordinate range.
  assign fin_sum = {h_q[CoefW-1], h_q} + (CoefW+1)'(1);
  assign half    = fin_sum[CoefW:1];
  assign fits    = (&half[CoefW-1:CoordW-1]) | ~(|half[CoefW-1:CoordW-1]);

  always_comb begin
    if (fits) begin
      res_o = half[CoordW-1:0];
    end else if (half[CoefW-1]) begin
      res_o = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(CoordW-1){1'b1}}};
    end
  end

endmodule

// ----- sv/cr_ctrl.sv -----
// ----------------------------------------------------------------------------
// Catmull-Rom sequencer
// Decodes commands, clamps neighbor indices and steps both lanes.
// ----------------------------------------------------------------------------
module cr_ctrl
  import cr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_i,
  input  logic [AddrW-1:0] point_index_i,
  input  logic [TW-1:0]    t_frac_i,
  input  logic [CntW-1:0]  point_count_i,
  input  logic             take_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output cr_lane_ctrl_t    lane_o
);

  state_e           state_q, state_d;
  logic [1:0]       cnt_q;
  logic [AddrW-1:0] nbr_q [4];
  logic [TW-1:0]    t_q;
  logic [1:0]       status_q;

  logic             accept, err;
  logic [CntW-1:0]  n, idx9, inc1, last;
  logic [CntW:0]    inc2;
  logic [AddrW-1:0] i0, i2, i3;
  logic [TW-1:0]    t_sat;

  assign accept = in_valid_i & in_ready_o;

  // Neighbor clamping against the active point count.
  assign n     = (point_count_i > MaxCount) ? MaxCount : point_count_i;
  assign idx9  = {1'b0, point_index_i};
  assign err   = idx9 >= n;
  assign inc1  = idx9 + CntW'(1);
  assign inc2  = {1'b0, idx9} + (CntW+1)'(2);
  assign last  = n - CntW'(1);
  assign i0    = (point_index_i == '0) ? '0 : point_index_i - AddrW'(1);
  assign i2    = (inc1 < n) ? inc1[AddrW-1:0] : last[AddrW-1:0];
  assign i3    = (inc2 < {1'b0, n}) ? inc2[AddrW-1:0] : last[AddrW-1:0];
  assign t_sat = (t_frac_i > TOne) ? TOne : t_frac_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (cmd_i == CMD_EVAL && !err) ? ST_READ : ST_DONE;
        end
      end
      ST_READ:  if (cnt_q == 2'd3) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_MUL;
      ST_MUL:   state_d = ST_ADD;
      ST_ADD:   if (cnt_q == 2'd2) state_d = ST_DONE; else state_d = ST_MUL;
      ST_DONE:  if (take_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      status_q <= STAT_STORE;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
        if (cmd_i == CMD_STORE) begin
          status_q <= STAT_STORE;
        end else if (err) begin
          status_q <= STAT_ERR;
        end else begin
          status_q <= STAT_EVAL;
        end
      end else if (state_q == ST_READ || state_q == ST_ADD) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (state_q == ST_DRAIN) begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      nbr_q[0] <= i0;
      nbr_q[1] <= point_index_i;
      nbr_q[2] <= i2;
      nbr_q[3] <= i3;
      t_q      <= t_sat;
    end
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    done_o        = (state_q == ST_DONE);
    status_o      = status_q;
    lane_o.wr_en  = accept & (cmd_i == CMD_STORE);
    lane_o.rd_en  = (state_q == ST_READ);
    lane_o.addr   = (state_q == ST_READ) ? nbr_q[cnt_q] : point_index_i;
    lane_o.tap    = tap_e'(cnt_q);
    lane_o.mul_en = (state_q == ST_MUL);
    lane_o.add_en = (state_q == ST_ADD);
    lane_o.coef   = coef_e'(cnt_q);
    lane_o.t      = t_q;
  end

endmodule

// ----- sv/catmull_rom_point_eval_unit.sv -----
// ----------------------------------------------------------------------------
// Catmull-Rom point evaluation unit
// Waypoint store with a two-lane (x, y) Catmull-Rom cubic evaluator.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Transaction contents
//  in_i      sink       valid/ready          cmd, point_index, point_x/y, t_frac
//  out_o     source     valid/ready          out_x, out_y, status
//  APB       slave      psel/penable/pready  point_count at byte 0
//
//  Store: written at acceptance, then its status is loaded as the result.
//  Evaluate: four store reads, one drain, three multiply/add Horner steps,
//  one output load. The next command is taken once the finished result has
//  been loaded into the output register.
//  One result parks in the output register; a second finished one holds the
//  sequencer and the command channel until out_o is taken.
//  Reset clears control and sets point_count to 4; the stores are not cleared.
// ----------------------------------------------------------------------------
`include "catmull_rom_point_eval_unit_defines.svh"

module catmull_rom_point_eval_unit
  import cr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cr_in_if.sink       in_i,
  cr_out_if.source    out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cr_lane_ctrl_t            lane_ctrl;
  logic                     done, take;
  logic [1:0]               ctrl_status;
  logic signed [CoordW-1:0] res_x, res_y;

  logic [CntW-1:0]          point_count_q;
  logic                     out_valid_q;
  logic signed [CoordW-1:0] out_x_q, out_y_q;
  logic [1:0]               out_status_q;
  logic [2:0]               reg_idx;

  // Configuration: one register, decoded on the word address bit.
  assign pready  = 1'b1;
  assign reg_idx = {2'b00, paddr[2]};
  assign prdata  = (reg_idx == REG_POINT_COUNT) ? 32'(point_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= CntW'(4);
    end else if (psel && penable && pwrite && pready && reg_idx == REG_POINT_COUNT) begin
      point_count_q <= pwdata[CntW-1:0];
    end
  end

  // Sequencer: command decode, neighbor clamping, lane stepping.
  cr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .cmd_i         (in_i.cmd),
    .point_index_i (in_i.point_index),
    .t_frac_i      (in_i.t_frac),
    .point_count_i (point_count_q),
    .take_i        (take),
    .done_o        (done),
    .status_o      (ctrl_status),
    .lane_o        (lane_ctrl)
  );

  // Lanes: x and y run the same schedule on their own stores.
  cr_lane u_lane_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lane_ctrl),
    .wdata_i (in_i.point_x),
    .res_o   (res_x)
  );

  cr_lane u_lane_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lane_ctrl),
    .wdata_i (in_i.point_y),
    .res_o   (res_y)
  );

  // Merge: join the lane results with status into the output register.
  // Drop coordinates to zero on store and error transactions.
  assign take = done & (~out_valid_q | out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_status_q <= ctrl_status;
      out_x_q      <= (ctrl_status == STAT_EVAL) ? res_x : '0;
      out_y_q      <= (ctrl_status == STAT_EVAL) ? res_y : '0;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.out_x  = out_x_q;
  assign out_o.out_y  = out_y_q;
  assign out_o.status = out_status_q;

  `CR_ASSERT_IMPL(a_nonpoint_zero, clk_i, rst_ni,
    out_valid_q && (out_status_q == STAT_STORE || out_status_q == STAT_ERR),
    out_x_q == '0 && out_y_q == '0, "store or error result with nonzero coordinates")
  `CR_ASSERT_NEXT(a_single_flight, clk_i, rst_ni, in_i.valid && in_i.ready,
    !in_i.ready, "command accepted while another is in flight")
  `CR_ASSERT_IMPL(a_load_from_done, clk_i, rst_ni, take, done && !in_i.ready,
    "output register loaded without a finished command")

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Catmull-Rom point evaluation unit testbench
// Drives store and evaluate transactions into the waypoint evaluator, keeps a
// shadow waypoint store and point count, recomputes every result with exact
// integer Horner arithmetic and checks each result transaction in order.
// Sweeps several point counts over the register port and several
// idle/stall mixes, including a long receiver hold-off that backs up the
// command channel.
// ----------------------------------------------------------------------------
module testbench
  import cr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 600000;
  localparam int SettleCycles = 24;
  localparam int HoldCycles   = 400;  // long receiver hold-off
  localparam int PhaseTotal   = 7;

  // Register byte addresses; index 1 is not implemented and must be ignored.
  localparam logic [2:0] PointCountAddr = 3'(REG_POINT_COUNT << 2);
  localparam logic [2:0] SpareRegAddr   = 3'd4;

  localparam logic signed [CoordW-1:0] CoordHi = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordLo = {1'b1, {(CoordW-1){1'b0}}};

  typedef struct packed {
    logic                     cmd;
    logic [AddrW-1:0]         point_index;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [TW-1:0]            t;
  } waypoint_cmd_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [1:0]               status;
  } point_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cr_in_if  in_bus ();
  cr_out_if out_bus ();

  catmull_rom_point_eval_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Commands waiting to be driven, and results waiting to be observed.
  waypoint_cmd_t pending_cmds[$];
  point_result_t expected_points[$];

  // Shadow of the block state as seen by the predictor.
  logic signed [CoordW-1:0] way_x [Depth];
  logic signed [CoordW-1:0] way_y [Depth];
  logic [CntW-1:0]          point_count_shadow = CntW'(4);

  // Stimulus side bookkeeping: which entries the queued stores will have filled.
  bit gen_written [Depth];
  int gen_count = 4;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  cmd_fire       = 1'b0;
  bit  backpressure_req  = 1'b0;
  bit  backpressure_seen = 1'b0;
  int  backpressure_left = 0;
  int  result_errors = 0;
  int  reg_errors    = 0;
  int  cycles        = 0;

  // Per-phase point count, idle mix, random transaction count, hold-off.
  // Counts 0 and 511 hit the "all errors" and "clamp to store depth" cases.
  int phase_points [PhaseTotal] = '{256,  1,  7,   0, 511,  37, 256};
  int phase_idle   [PhaseTotal] = '{  0, 48,  0,  16,  16,   0,   0};
  int phase_stall  [PhaseTotal] = '{  0,  0, 48,  16,  16,  48,   0};
  int phase_items  [PhaseTotal] = '{250, 250, 300, 100, 300, 300, 300};
  bit phase_press  [PhaseTotal] = '{  0,  0,  0,   0,   0,   0,   1};

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // One axis of the uniform Catmull-Rom cubic: Horner on exact integer
  // coefficients, round half up after each multiply by t, halve with round
  // half up, then saturate to the coordinate range.
  function automatic logic signed [CoordW-1:0] spline_axis(longint p0, longint p1,
                                                           longint p2, longint p3,
                                                           longint t);
    longint half_lsb;
    longint sat_hi;
    longint sat_lo;
    longint h;
    longint r;
    half_lsb = longint'(1) << (TFracBits - 1);
    sat_hi   = (longint'(1) << (CoordW - 1)) - 1;
    sat_lo   = -sat_hi - 1;
    h = -p0 + 3 * p1 - 3 * p2 + p3;
    h = (2 * p0 - 5 * p1 + 4 * p2 - p3) + ((h * t + half_lsb) >>> TFracBits);
    h = (p2 - p0) + ((h * t + half_lsb) >>> TFracBits);
    h = (2 * p1) + ((h * t + half_lsb) >>> TFracBits);
    r = (h + 1) >>> 1;
    if (r > sat_hi) r = sat_hi;
    if (r < sat_lo) r = sat_lo;
    return CoordW'(r);
  endfunction

  // Apply one accepted command to the shadow state and return its result.
  function automatic point_result_t predict_point(waypoint_cmd_t c);
    point_result_t   r;
    logic [CntW-1:0] n;
    logic [TW-1:0]   t;
    int              ni;
    int              i0;
    int              i1;
    int              i2;
    int              i3;
    r = '0;
    if (c.cmd == CMD_STORE) begin
      // The index field cannot reach past the store, so every store lands.
      way_x[c.point_index] = c.x;
      way_y[c.point_index] = c.y;
      r.status = STAT_STORE;
      return r;
    end
    n = (point_count_shadow > MaxCount) ? MaxCount : point_count_shadow;
    if (CntW'(c.point_index) >= n) begin
      r.status = STAT_ERR;
      return r;
    end
    t  = (c.t > TOne) ? TOne : c.t;
    ni = int'(n);
    i1 = int'(c.point_index);
    i0 = (i1 > 0) ? i1 - 1 : 0;
    i2 = (i1 + 1 < ni) ? i1 + 1 : ni - 1;
    i3 = (i1 + 2 < ni) ? i1 + 2 : ni - 1;
    r.x = spline_axis(way_x[i0], way_x[i1], way_x[i2], way_x[i3], longint'(t));
    r.y = spline_axis(way_y[i0], way_y[i1], way_y[i2], way_y[i3], longint'(t));
    r.status = STAT_EVAL;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------

  function automatic int eff_points(int c);
    return (c > Depth) ? Depth : c;
  endfunction

  // Mix extremes, zero, small values and full-range noise.
  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return CoordHi;
      1:       return CoordLo;
      2:       return CoordW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      3:       return '0;
      default: return CoordW'($urandom);
    endcase
  endfunction

  // Bias t toward both ends and the saturated range above one.
  function automatic logic [TW-1:0] rand_t();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return TOne;
      2:       return TW'($urandom_range(int'(TOne) + 1, (1 << TW) - 1));
      default: return TW'($urandom_range(0, int'(TOne)));
    endcase
  endfunction

  task automatic queue_store(int idx, logic signed [CoordW-1:0] x,
                             logic signed [CoordW-1:0] y);
    pending_cmds.push_back('{cmd: CMD_STORE, point_index: AddrW'(idx), x: x, y: y,
                             t: rand_t()});
    gen_written[idx] = 1'b1;
  endtask

  // Queue an evaluate; fill any neighbor it would read that was never written,
  // so no transaction ever reads an undefined entry.
  task automatic queue_eval(int idx, logic [TW-1:0] t);
    int n;
    int taps [4];
    n = eff_points(gen_count);
    if (idx < n) begin
      taps = '{(idx > 0) ? idx - 1 : 0, idx,
               (idx + 1 < n) ? idx + 1 : n - 1,
               (idx + 2 < n) ? idx + 2 : n - 1};
      foreach (taps[k]) begin
        if (!gen_written[taps[k]]) queue_store(taps[k], rand_coord(), rand_coord());
      end
    end
    pending_cmds.push_back('{cmd: CMD_EVAL, point_index: AddrW'(idx), x: rand_coord(),
                             y: rand_coord(), t: t});
  endtask

  task automatic queue_random();
    int n;
    int idx;
    n = eff_points(gen_count);
    if ($urandom_range(0, 99) < 40) begin
      // Half the stores stay inside the active points so they get read back.
      idx = (n > 0 && $urandom_range(0, 1) == 1) ? $urandom_range(0, n - 1)
                                                 : $urandom_range(0, Depth - 1);
      queue_store(idx, rand_coord(), rand_coord());
    end else begin
      case ($urandom_range(0, 9))
        0:       idx = $urandom_range(0, Depth - 1);  // often out of range
        1:       idx = (n > 0) ? n - 1 : 0;           // last segment
        2:       idx = 0;                             // first segment
        default: idx = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, Depth - 1);
      endcase
      queue_eval(idx, rand_t());
    end
  endtask

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // Track the write in the shadow; writes to other indexes are dropped.
    if (3'(addr >> 2) == REG_POINT_COUNT) point_count_shadow = data[CntW-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(logic [2:0] addr, output logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_point_count();
    logic [31:0] readback;
    apb_read(PointCountAddr, readback);
    if (readback[CntW-1:0] !== point_count_shadow) begin
      $error("point_count readback: expected %0d, got %0d",
             point_count_shadow, readback[CntW-1:0]);
      reg_errors++;
    end
  endtask

  // Wait until every command is sent and every result is back, then let the
  // pipeline settle before touching the register again.
  task automatic drain_and_settle();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || in_bus.valid || expected_points.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Clock, driver, receiver, monitor
  // --------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Command driver: hold valid until the transaction is taken, then offer the
  // next one or idle at the phase's rate. Change inputs on the falling edge.
  always @(negedge clk_i) begin : feed_commands
    waypoint_cmd_t next_cmd;
    if (rst_ni && (!in_bus.valid || cmd_fire)) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_cmd = pending_cmds.pop_front();
        in_bus.valid       <= 1'b1;
        in_bus.cmd         <= next_cmd.cmd;
        in_bus.point_index <= next_cmd.point_index;
        in_bus.point_x     <= next_cmd.x;
        in_bus.point_y     <= next_cmd.y;
        in_bus.t_frac      <= next_cmd.t;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off whenever the
  // stimulus flips the request bit. Count the hold-off here.
  always @(negedge clk_i) begin : drain_results
    if (backpressure_req != backpressure_seen) begin
      backpressure_seen = backpressure_req;
      backpressure_left = HoldCycles;
    end
    if (backpressure_left > 0) begin
      backpressure_left = backpressure_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: sample both channels on the rising edge. Check the outgoing
  // result first so a result never matches a command taken on the same edge.
  always @(posedge clk_i) begin : watch_channels
    point_result_t want;
    waypoint_cmd_t got_cmd;
    cmd_fire = rst_ni && in_bus.valid && in_bus.ready;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result: out_x=%0d out_y=%0d status=%0d",
               out_bus.out_x, out_bus.out_y, out_bus.status);
        result_errors++;
      end else begin
        want = expected_points.pop_front();
        if (out_bus.out_x !== want.x) begin
          $error("out_x mismatch: expected %0d, got %0d", want.x, out_bus.out_x);
          result_errors++;
        end
        if (out_bus.out_y !== want.y) begin
          $error("out_y mismatch: expected %0d, got %0d", want.y, out_bus.out_y);
          result_errors++;
        end
        if (out_bus.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_bus.status);
          result_errors++;
        end
      end
    end
    if (cmd_fire) begin
      got_cmd.cmd         = in_bus.cmd;
      got_cmd.point_index = in_bus.point_index;
      got_cmd.x           = in_bus.point_x;
      got_cmd.y           = in_bus.point_y;
      got_cmd.t           = in_bus.t_frac;
      expected_points.push_back(predict_point(got_cmd));
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin : run_sequence
    // Drive every input to a known value before the first edge.
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_bus.valid       = 1'b0;
    in_bus.cmd         = CMD_STORE;
    in_bus.point_index = '0;
    in_bus.point_x     = '0;
    in_bus.point_y     = '0;
    in_bus.t_frac      = '0;
    out_bus.ready      = 1'b0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed pass at the reset point count of 4, no idling.
    // Fill all four points with alternating extremes so the middle segment
    // overshoots past both ends of the coordinate range.
    queue_store(0, CoordLo, CoordHi);
    queue_store(1, CoordHi, CoordLo);
    queue_store(2, CoordHi, CoordLo);
    queue_store(3, CoordLo, CoordHi);
    queue_eval(1, TOne >> 1);            // saturates high on x, low on y
    queue_eval(0, '0);                   // lower neighbor clamped, gives P1
    queue_eval(0, TOne);                 // gives P2
    queue_eval(2, {TW{1'b1}});           // t above one; top neighbor clamped
    queue_eval(3, TW'(1));               // both upper neighbors clamped
    queue_eval(4, TOne >> 1);            // index at point count: error
    queue_eval(Depth - 1, '0);           // highest index: error
    queue_store(Depth - 1, 32'sh0001_8000, -32'sh0001_8000);  // top entry
    queue_store(2, '0, -32'sd1);
    queue_store(1, 32'sh0000_4000, -32'sh0002_0000);
    queue_eval(1, TW'(12345));
    queue_eval(2, TW'(40000));
    drain_and_settle();
    check_point_count();

    // Random phases: each one sets the point count while the block is idle.
    for (int p = 0; p < PhaseTotal; p++) begin
      apb_write(PointCountAddr, 32'(phase_points[p]));
      if (p == 0) apb_write(SpareRegAddr, 32'h0000_0003);  // dropped by the block
      check_point_count();
      gen_count      = phase_points[p];
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      repeat (phase_items[p]) queue_random();
      // Hold the receiver off while the sender keeps offering, so the output
      // register fills and the command channel stalls.
      if (phase_press[p]) backpressure_req = !backpressure_req;
      drain_and_settle();
    end

    if (result_errors == 0 && reg_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/cr_pkg.sv
sv/cr_in_if.sv
sv/cr_out_if.sv
sv/cr_lane.sv
sv/cr_ctrl.sv
sv/catmull_rom_point_eval_unit.sv
tb/testbench.sv
